// File: hdl/tloc_pkg.sv
`default_nettype none
package tloc_pkg;

  localparam int CoordW  = 31;
  localparam int WidthW  = 25;
  localparam int BloatW  = 25;
  localparam int OutW    = 32;
  localparam int DeltaW  = 32;
  localparam int NormW   = 64;
  localparam int AddrW   = 1;
  localparam logic [AddrW-1:0] RegBloat = 1'b0;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [WidthW-1:0] line_width;
    logic              square_cap;
  } seg_t;

  typedef struct packed {
    logic        bad;
    seg_t        seg;
  } ctl_t;

endpackage
`default_nettype wire

// File: hdl/tloc_div_cell.sv
`default_nettype none
// One restoring division step per cell: quotient bit of mag^2 * 2^(2F) / n.
module tloc_div_cell
  import tloc_pkg::*;
#(
  parameter int QW = 33
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NormW-1:0] n_i,
  input  wire logic [NormW:0]   rem_x_i,
  input  wire logic [NormW:0]   rem_y_i,
  input  wire logic [QW-1:0]    q_x_i,
  input  wire logic [QW-1:0]    q_y_i,
  output logic      [NormW-1:0] n_o,
  output logic      [NormW:0]   rem_x_o,
  output logic      [NormW:0]   rem_y_o,
  output logic      [QW-1:0]    q_x_o,
  output logic      [QW-1:0]    q_y_o
);
  logic [NormW+1:0] sx, sy;
  logic bx, by;

  always_comb begin
    sx = {rem_x_i, 1'b0};
    sy = {rem_y_i, 1'b0};
    bx = sx >= {2'b00, n_i};
    by = sy >= {2'b00, n_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o     <= n_i;
      rem_x_o <= bx ? (NormW+1)'(sx - {2'b00, n_i}) : sx[NormW:0];
      rem_y_o <= by ? (NormW+1)'(sy - {2'b00, n_i}) : sy[NormW:0];
      q_x_o   <= {q_x_i[QW-2:0], bx};
      q_y_o   <= {q_y_i[QW-2:0], by};
    end
  end
endmodule
`default_nettype wire

// File: hdl/tloc_sqrt_cell.sv
`default_nettype none
// One bit-pair step of the integer square root, for both components.
module tloc_sqrt_cell
  import tloc_pkg::*;
#(
  parameter int RW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [2*RW-1:0] x_i,
  input  wire logic [2*RW-1:0] y_i,
  input  wire logic [RW-1:0] rx_i,
  input  wire logic [RW-1:0] ry_i,
  input  wire logic [2*RW-1:0] ex_i,
  input  wire logic [2*RW-1:0] ey_i,
  output logic      [2*RW-1:0] x_o,
  output logic      [2*RW-1:0] y_o,
  output logic      [RW-1:0] rx_o,
  output logic      [RW-1:0] ry_o,
  output logic      [2*RW-1:0] ex_o,
  output logic      [2*RW-1:0] ey_o
);
  // Remainder ex holds x - r^2 progressively; x shifts two bits per cell.
  logic [2*RW+1:0] tx, ty, cx, cy;

  always_comb begin
    tx = {ex_i, x_i[2*RW-1 -: 2]};
    ty = {ey_i, y_i[2*RW-1 -: 2]};
    cx = {{RW{1'b0}}, rx_i, 2'b01};
    cy = {{RW{1'b0}}, ry_i, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o  <= {x_i[2*RW-3:0], 2'b00};
      y_o  <= {y_i[2*RW-3:0], 2'b00};
      rx_o <= {rx_i[RW-2:0], tx >= cx};
      ry_o <= {ry_i[RW-2:0], ty >= cy};
      ex_o <= (tx >= cx) ? (2*RW)'(tx - cx) : tx[2*RW-1:0];
      ey_o <= (ty >= cy) ? (2*RW)'(ty - cy) : ty[2*RW-1:0];
    end
  end
endmodule
`default_nettype wire

// File: hdl/thick_line_outline_corners_unit.sv
`default_nettype none
// Thick line outline corners.
// Input stream s_axis: one word per segment; output m_axis: the four corners
// and an error flag in tuser. Configuration over APB: bloat_amount at 0x0.
// The unit direction is computed by a chain of cells: the norm stage forms the
// first quotient bit, then one restoring division cell per further quotient
// bit (2*FRACTION_BITS of them) and one square-root cell per result bit, plus
// a few stages for the squares, the products and the rounding. Throughput is
// one word per cycle while the receiver takes words. The whole
// chain advances only when the output register can take a word, so a stalled
// receiver holds every stage and lowers s_axis_tready.
// Reset clears the valid bits of all stages and sets bloat_amount to zero.
// A zero-length segment or a non-positive grown half-width returns all
// corners zero with tuser set.
module thick_line_outline_corners_unit
  import tloc_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [AddrW+1:0] paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_x[30:0], start_y[61:31], end_x[92:62], end_y[123:93],
  // line_width[148:124], square_cap[149], zero fill to 152
  input  wire logic [151:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, each 32 bits from the lowest bit up
  output logic      [255:0] m_axis_tdata,
  // bad_input
  output logic              m_axis_tuser
);
  localparam int F    = FRACTION_BITS;
  localparam int QW   = 2*F + 1;
  localparam int ND   = 2*F + 1;
  localparam int RW   = F + 1;
  localparam int SW   = 2*RW;
  localparam int UW   = F + 2;
  localparam int PW   = 27 + UW;
  localparam int SUMW = 34 + F + 1;

  logic [BloatW-1:0] bloat_q;
  logic adv;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bloat_q <= '0;
    end else if (psel && penable && pwrite && paddr[AddrW+1:2] == RegBloat) begin
      bloat_q <= pwdata[BloatW-1:0];
    end
  end
  assign prdata = (paddr[AddrW+1:2] == RegBloat) ?
                  {{(32-BloatW){bloat_q[BloatW-1]}}, bloat_q} : 32'd0;

  seg_t in_seg;
  assign in_seg = '{start_x: s_axis_tdata[30:0], start_y: s_axis_tdata[61:31],
                    end_x: s_axis_tdata[92:62], end_y: s_axis_tdata[123:93],
                    line_width: s_axis_tdata[148:124], square_cap: s_axis_tdata[149]};

  // Stage 0: deltas and the error check.
  ctl_t c0_q;
  logic v0_q;
  logic signed [DeltaW-1:0] dx0_q, dy0_q;
  logic signed [DeltaW-1:0] dx_c, dy_c;
  logic signed [WidthW+1:0] hw_c;
  always_comb begin
    dx_c = DeltaW'($signed(in_seg.end_x)) - DeltaW'($signed(in_seg.start_x));
    dy_c = DeltaW'($signed(in_seg.end_y)) - DeltaW'($signed(in_seg.start_y));
    hw_c = $signed({3'b000, in_seg.line_width[WidthW-1:1]})
         + (WidthW+2)'($signed(bloat_q));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_q.seg <= in_seg;
      c0_q.bad <= (dx_c == '0 && dy_c == '0) || (hw_c <= 0);
      dx0_q <= dx_c;
      dy0_q <= dy_c;
    end
  end

  // Stage 1: squares.
  ctl_t c1_q;
  logic v1_q;
  logic [NormW-1:0] sqx_q, sqy_q;
  logic [DeltaW-1:0] ax, ay;
  assign ax = dx0_q[DeltaW-1] ? DeltaW'(-dx0_q) : dx0_q;
  assign ay = dy0_q[DeltaW-1] ? DeltaW'(-dy0_q) : dy0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= v0_q;
  end
  logic sgx1_q, sgy1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= c0_q;
      sqx_q <= ax * ax; sqy_q <= ay * ay;
      sgx1_q <= dx0_q[DeltaW-1]; sgy1_q <= dy0_q[DeltaW-1];
    end
  end

  // Stage 2: norm and the first quotient bit.
  ctl_t c2_q;
  logic v2_q;
  logic [NormW-1:0] n2_q;
  logic [NormW:0] rx2_q, ry2_q;
  logic [QW-1:0] qx2_q, qy2_q;
  logic sgx2_q, sgy2_q;
  logic [NormW-1:0] n_c;
  assign n_c = sqx_q + sqy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q <= c1_q;
      sgx2_q <= sgx1_q; sgy2_q <= sgy1_q;
      n2_q <= n_c;
      rx2_q <= (sqx_q >= n_c) ? {1'b0, NormW'(sqx_q - n_c)} : {1'b0, sqx_q};
      ry2_q <= (sqy_q >= n_c) ? {1'b0, NormW'(sqy_q - n_c)} : {1'b0, sqy_q};
      qx2_q <= QW'(sqx_q >= n_c);
      qy2_q <= QW'(sqy_q >= n_c);
    end
  end

  // Division cells with a side chain for control. Entry 0 is the norm stage.
  logic [NormW-1:0] dn   [ND];
  logic [NormW:0]   drx  [ND];
  logic [NormW:0]   dry  [ND];
  logic [QW-1:0]    dqx  [ND];
  logic [QW-1:0]    dqy  [ND];
  ctl_t             dctl [ND];
  logic             dv   [ND];
  logic             dsx  [ND];
  logic             dsy  [ND];
  assign dn[0] = n2_q; assign drx[0] = rx2_q; assign dry[0] = ry2_q;
  assign dqx[0] = qx2_q; assign dqy[0] = qy2_q;
  assign dctl[0] = c2_q; assign dv[0] = v2_q;
  assign dsx[0] = sgx2_q; assign dsy[0] = sgy2_q;
  for (genvar i = 0; i < 2*F; i++) begin : g_div
    tloc_div_cell #(.QW(QW)) u_cell (
      .clk_i, .en_i(adv),
      .n_i(dn[i]),
      .rem_x_i(drx[i]), .rem_y_i(dry[i]),
      .q_x_i(dqx[i]), .q_y_i(dqy[i]),
      .n_o(dn[i+1]), .rem_x_o(drx[i+1]), .rem_y_o(dry[i+1]),
      .q_x_o(dqx[i+1]), .q_y_o(dqy[i+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv[i+1] <= 1'b0;
      else if (adv) dv[i+1] <= dv[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dctl[i+1] <= dctl[i];
        dsx[i+1] <= dsx[i];
        dsy[i+1] <= dsy[i];
      end
    end
  end

  // Square-root cells.
  logic [SW-1:0] sx_a [RW+1];
  logic [SW-1:0] sy_a [RW+1];
  logic [RW-1:0] srx  [RW+1];
  logic [RW-1:0] sry  [RW+1];
  logic [SW-1:0] sex  [RW+1];
  logic [SW-1:0] sey  [RW+1];
  ctl_t          sctl [RW+1];
  logic          sv   [RW+1];
  logic          ssx  [RW+1];
  logic          ssy  [RW+1];
  assign sx_a[0] = SW'(dqx[2*F]);
  assign sy_a[0] = SW'(dqy[2*F]);
  assign srx[0] = '0; assign sry[0] = '0;
  assign sex[0] = '0; assign sey[0] = '0;
  assign sctl[0] = dctl[2*F]; assign sv[0] = dv[2*F];
  assign ssx[0] = dsx[2*F]; assign ssy[0] = dsy[2*F];
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    tloc_sqrt_cell #(.RW(RW)) u_cell (
      .clk_i, .en_i(adv),
      .x_i(sx_a[j]), .y_i(sy_a[j]), .rx_i(srx[j]), .ry_i(sry[j]),
      .ex_i(sex[j]), .ey_i(sey[j]),
      .x_o(sx_a[j+1]), .y_o(sy_a[j+1]), .rx_o(srx[j+1]), .ry_o(sry[j+1]),
      .ex_o(sex[j+1]), .ey_o(sey[j+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv[j+1] <= 1'b0;
      else if (adv) sv[j+1] <= sv[j];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sctl[j+1] <= sctl[j];
        ssx[j+1] <= ssx[j]; ssy[j+1] <= ssy[j];
      end
    end
  end

  // Products stage: 2A*n and 2B*u.
  logic signed [UW-1:0] ux, uy;
  assign ux = ssx[RW] ? UW'(-$signed({1'b0, srx[RW]})) : $signed({1'b0, srx[RW]});
  assign uy = ssy[RW] ? UW'(-$signed({1'b0, sry[RW]})) : $signed({1'b0, sry[RW]});
  logic signed [26:0] a2, b2;
  assign a2 = $signed({2'b00, sctl[RW].seg.line_width})
            + 27'($signed({bloat_q, 1'b0}));
  assign b2 = $signed({2'b00, sctl[RW].seg.square_cap ? sctl[RW].seg.line_width
                                                       : {WidthW{1'b0}}})
            + 27'($signed({bloat_q, 1'b0}));
  ctl_t cp_q;
  logic vp_q;
  logic signed [PW-1:0] anx_q, any_q, bux_q, buy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (adv) vp_q <= sv[RW];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_q <= sctl[RW];
      anx_q <= PW'(a2 * -uy); any_q <= PW'(a2 * ux);
      bux_q <= PW'(b2 * ux);  buy_q <= PW'(b2 * uy);
    end
  end

  // Sum, round and saturate.
  function automatic logic [OutW-1:0] rnd_sat(input logic signed [SUMW-1:0] v);
    logic [SUMW-1:0] mag, r;
    mag = v[SUMW-1] ? SUMW'(-v) : v;
    r = (mag + (SUMW'(1) << F)) >> (F + 1);
    if (!v[SUMW-1]) rnd_sat = (r > SUMW'(32'h7fffffff)) ? 32'h7fffffff : r[OutW-1:0];
    else rnd_sat = (r > SUMW'(33'h80000000)) ? 32'h80000000 : OutW'(-r);
  endfunction

  function automatic logic signed [SUMW-1:0] pt(input logic [CoordW-1:0] c);
    pt = SUMW'($signed(c)) <<< (F + 1);
  endfunction

  logic [8*OutW-1:0] res;
  always_comb begin
    res[0*OutW +: OutW] = rnd_sat(pt(cp_q.seg.start_x) + SUMW'(anx_q) - SUMW'(bux_q));
    res[1*OutW +: OutW] = rnd_sat(pt(cp_q.seg.start_y) + SUMW'(any_q) - SUMW'(buy_q));
    res[2*OutW +: OutW] = rnd_sat(pt(cp_q.seg.end_x) + SUMW'(anx_q) + SUMW'(bux_q));
    res[3*OutW +: OutW] = rnd_sat(pt(cp_q.seg.end_y) + SUMW'(any_q) + SUMW'(buy_q));
    res[4*OutW +: OutW] = rnd_sat(pt(cp_q.seg.end_x) - SUMW'(anx_q) + SUMW'(bux_q));
    res[5*OutW +: OutW] = rnd_sat(pt(cp_q.seg.end_y) - SUMW'(any_q) + SUMW'(buy_q));
    res[6*OutW +: OutW] = rnd_sat(pt(cp_q.seg.start_x) - SUMW'(anx_q) - SUMW'(bux_q));
    res[7*OutW +: OutW] = rnd_sat(pt(cp_q.seg.start_y) - SUMW'(any_q) - SUMW'(buy_q));
    if (cp_q.bad) res = '0;
  end

  logic ov_q;
  assign adv = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vp_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= res;
      m_axis_tuser <= cp_q.bad;
    end
  end
  assign m_axis_tvalid = ov_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error word carries corners");
`endif
endmodule
`default_nettype wire
